// File: design/flm_pkg.sv
// Package with the shared types and constants of the FLAC metadata block locator.
`timescale 1ns / 1ps

package flm_pkg;

    // Width of the saturating file position counter (16 to 64).
    localparam int OFFSET_WIDTH = 32;
    localparam logic [OFFSET_WIDTH-1:0] POS_MAX = {OFFSET_WIDTH{1'b1}};

    // File signatures.
    localparam logic [31:0] SIG_FLAC = 32'h664C_6143;
    localparam logic [23:0] SIG_ID3  = 24'h49_4433;

    // Result queue geometry: room for the two results one byte can cause.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Parser phases.
    typedef enum logic [2:0] {
        PH_SIG,
        PH_TAGHDR,
        PH_TAGBODY,
        PH_SIG2,
        PH_HDR,
        PH_SKIP,
        PH_PAYLOAD,
        PH_DONE
    } t_phase;

    // Result kinds.
    typedef enum logic [2:0] {
        KIND_PAYLOAD   = 3'd0,
        KIND_FOUND     = 3'd1,
        KIND_NOT_FLAC  = 3'd2,
        KIND_NO_MATCH  = 3'd3,
        KIND_EARLY_END = 3'd4
    } t_kind;

    // One result item.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic        payload_last;
        logic [23:0] block_length;
        logic [31:0] payload_offset;
    } t_result;

    // Results written into the queue for one accepted byte, in order.
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

    // Queue status seen by the top level.
    typedef struct packed {
        logic [FIFO_AW:0] count;
        logic             room_for_two;
    } t_fifo_status;

endpackage

// File: design/flm_in_if.sv
// Input byte channel of the FLAC metadata block locator.
`timescale 1ns / 1ps

interface flm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output first_byte, output final_byte,
                    input ready);
    modport sink   (input valid, input data_byte, input first_byte, input final_byte,
                    output ready);
endinterface

// File: design/flm_out_if.sv
// Result channel of the FLAC metadata block locator.
`timescale 1ns / 1ps

interface flm_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  payload_byte;
    logic        payload_last;
    logic [23:0] block_length;
    logic [31:0] payload_offset;

    modport source (output valid, output kind, output payload_byte, output payload_last,
                    output block_length, output payload_offset, input ready);
    modport sink   (input valid, input kind, input payload_byte, input payload_last,
                    input block_length, input payload_offset, output ready);
endinterface

// File: design/flm_parser.sv
// Byte parser: ID3 skip, signature check, header walk and payload pass-through.
`timescale 1ns / 1ps

module flm_parser
    import flm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_first_byte,
    input  logic       i_final_byte,
    input  logic [6:0] i_wanted_type,
    output t_push      o_push
);

    t_phase                  r_phase, n_phase, s_phase;
    logic [2:0]              r_field, n_field, s_field;
    logic [31:0]             r_sig, n_sig, s_sig;
    logic [27:0]             r_skip, n_skip, s_skip;
    logic [27:0]             r_len, n_len, s_len;
    logic                    r_final, n_final, s_final;
    logic                    r_match, n_match, s_match;
    logic [OFFSET_WIDTH-1:0] r_pos, n_pos;

    logic [31:0] sig_shift;
    logic [27:0] tag_len;
    logic [23:0] hdr_len;
    logic [27:0] skip_dec;
    logic [63:0] pos_ext;
    logic [31:0] pos_clamped;
    logic        p_valid;
    t_result     p_res;
    t_result     e_res;

    // A first byte restarts the parser before the byte is taken.
    always_comb begin
        if (i_first_byte) begin
            s_phase = PH_SIG;
            s_field = '0;
            s_sig   = '0;
            s_skip  = '0;
            s_len   = '0;
            s_final = 1'b0;
            s_match = 1'b0;
        end else begin
            s_phase = r_phase;
            s_field = r_field;
            s_sig   = r_sig;
            s_skip  = r_skip;
            s_len   = r_len;
            s_final = r_final;
            s_match = r_match;
        end
    end

    // Shared datapath terms.
    assign sig_shift = {s_sig[23:0], i_data_byte};
    assign tag_len   = {s_len[20:0], i_data_byte[6:0]};
    assign hdr_len   = {s_len[15:0], i_data_byte};
    assign skip_dec  = s_skip - 28'd1;

    // Position counts bytes since the file start and saturates.
    always_comb begin
        if (i_first_byte) begin
            n_pos = OFFSET_WIDTH'(1);
        end else if (r_pos == POS_MAX) begin
            n_pos = r_pos;
        end else begin
            n_pos = r_pos + OFFSET_WIDTH'(1);
        end
    end

    assign pos_ext     = 64'(n_pos);
    assign pos_clamped = (pos_ext > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : pos_ext[31:0];

    // Next state of the parser.
    always_comb begin
        n_phase = s_phase;
        n_field = s_field;
        n_sig   = s_sig;
        n_skip  = s_skip;
        n_len   = s_len;
        n_final = s_final;
        n_match = s_match;
        unique case (s_phase)
            PH_SIG, PH_SIG2: begin
                n_sig = sig_shift;
                if (s_field < 3'd3) begin
                    n_field = s_field + 3'd1;
                end else begin
                    n_field = '0;
                    if (s_phase == PH_SIG && sig_shift[31:8] == SIG_ID3) begin
                        n_len   = '0;
                        n_phase = PH_TAGHDR;
                    end else if (sig_shift == SIG_FLAC) begin
                        n_phase = PH_HDR;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
            end
            PH_TAGHDR: begin
                if (s_field >= 3'd2 && i_data_byte[7]) begin
                    n_phase = PH_DONE;
                end else begin
                    if (s_field >= 3'd2) begin
                        n_len = tag_len;
                    end
                    if (s_field < 3'd5) begin
                        n_field = s_field + 3'd1;
                    end else begin
                        n_field = '0;
                        n_sig   = '0;
                        n_skip  = tag_len;
                        n_phase = (tag_len != '0) ? PH_TAGBODY : PH_SIG2;
                    end
                end
            end
            PH_TAGBODY: begin
                n_skip = skip_dec;
                if (skip_dec == '0) begin
                    n_phase = PH_SIG2;
                end
            end
            PH_HDR: begin
                if (s_field == '0) begin
                    n_final = i_data_byte[7];
                    n_match = (i_data_byte[6:0] == i_wanted_type);
                    n_len   = '0;
                    n_field = 3'd1;
                end else begin
                    n_len = {4'd0, hdr_len};
                    if (s_field < 3'd3) begin
                        n_field = s_field + 3'd1;
                    end else begin
                        n_field = '0;
                        n_skip  = {4'd0, hdr_len};
                        if (s_match) begin
                            n_phase = (hdr_len != '0) ? PH_PAYLOAD : PH_DONE;
                        end else if (s_final) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_phase = (hdr_len != '0) ? PH_SKIP : PH_HDR;
                        end
                    end
                end
            end
            PH_SKIP: begin
                n_skip = skip_dec;
                if (skip_dec == '0) begin
                    n_phase = PH_HDR;
                end
            end
            PH_PAYLOAD: begin
                n_skip = skip_dec;
                if (skip_dec == '0) begin
                    n_phase = PH_DONE;
                end
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase
        // An early end closes the file whatever the byte did.
        if (i_final_byte) begin
            n_phase = PH_DONE;
        end
    end

    // Result caused by the byte itself.
    always_comb begin
        p_valid = 1'b0;
        p_res   = '0;
        unique case (s_phase)
            PH_SIG, PH_SIG2: begin
                if (s_field == 3'd3 &&
                    !(s_phase == PH_SIG && sig_shift[31:8] == SIG_ID3) &&
                    sig_shift != SIG_FLAC) begin
                    p_valid    = 1'b1;
                    p_res.kind = KIND_NOT_FLAC;
                end
            end
            PH_TAGHDR: begin
                if (s_field >= 3'd2 && i_data_byte[7]) begin
                    p_valid    = 1'b1;
                    p_res.kind = KIND_NOT_FLAC;
                end
            end
            PH_HDR: begin
                if (s_field == 3'd3) begin
                    if (s_match) begin
                        p_valid              = 1'b1;
                        p_res.kind           = KIND_FOUND;
                        p_res.payload_last   = (hdr_len == '0);
                        p_res.block_length   = hdr_len;
                        p_res.payload_offset = pos_clamped;
                    end else if (s_final) begin
                        p_valid    = 1'b1;
                        p_res.kind = KIND_NO_MATCH;
                    end
                end
            end
            PH_PAYLOAD: begin
                p_valid            = 1'b1;
                p_res.kind         = KIND_PAYLOAD;
                p_res.payload_byte = i_data_byte;
                p_res.payload_last = (skip_dec == '0);
            end
            PH_TAGBODY, PH_SKIP, PH_DONE: begin
                p_valid = 1'b0;
            end
            default: begin
                p_valid = 1'b0;
            end
        endcase
    end

    // The early-end report that follows any result of the same byte.
    always_comb begin
        e_res      = '0;
        e_res.kind = KIND_EARLY_END;
    end

    logic ends_early;
    // Work out the phase the byte leaves behind, before the final-byte override.
    t_phase step_phase;
    always_comb begin
        step_phase = s_phase;
        unique case (s_phase)
            PH_SIG, PH_SIG2: begin
                if (s_field == 3'd3) begin
                    if (s_phase == PH_SIG && sig_shift[31:8] == SIG_ID3) begin
                        step_phase = PH_TAGHDR;
                    end else if (sig_shift == SIG_FLAC) begin
                        step_phase = PH_HDR;
                    end else begin
                        step_phase = PH_DONE;
                    end
                end
            end
            PH_TAGHDR: begin
                if (s_field >= 3'd2 && i_data_byte[7]) begin
                    step_phase = PH_DONE;
                end else if (s_field == 3'd5) begin
                    step_phase = (tag_len != '0) ? PH_TAGBODY : PH_SIG2;
                end
            end
            PH_HDR: begin
                if (s_field == 3'd3 && (s_match || s_final)) begin
                    step_phase = (s_match && hdr_len != '0) ? PH_PAYLOAD : PH_DONE;
                end
            end
            PH_PAYLOAD: begin
                if (skip_dec == '0) begin
                    step_phase = PH_DONE;
                end
            end
            PH_TAGBODY, PH_SKIP, PH_DONE: begin
                step_phase = s_phase;
            end
            default: begin
                step_phase = PH_DONE;
            end
        endcase
    end
    assign ends_early = i_final_byte && (step_phase != PH_DONE);

    // Results handed to the queue, packed in order.
    always_comb begin
        o_push = '0;
        if (i_accept) begin
            if (p_valid) begin
                o_push.res0  = p_res;
                o_push.res1  = e_res;
                o_push.count = ends_early ? 2'd2 : 2'd1;
            end else if (ends_early) begin
                o_push.res0  = e_res;
                o_push.count = 2'd1;
            end
        end
    end

    // Parser state registers, updated on each input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIG;
            r_field <= '0;
            r_sig   <= '0;
            r_skip  <= '0;
            r_len   <= '0;
            r_final <= 1'b0;
            r_match <= 1'b0;
            r_pos   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_field <= n_field;
            r_sig   <= n_sig;
            r_skip  <= n_skip;
            r_len   <= n_len;
            r_final <= n_final;
            r_match <= n_match;
            r_pos   <= n_pos;
        end
    end

endmodule

// File: design/flm_result_fifo.sv
// Four-entry result queue taking up to two results per cycle and giving one.
`timescale 1ns / 1ps

module flm_result_fifo
    import flm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_push        i_push,
    input  logic         i_pop,
    output logic         o_valid,
    output t_result      o_head,
    output t_fifo_status o_status
);

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr, n_wr;
    logic [FIFO_AW-1:0]   r_rd, n_rd;
    logic [FIFO_AW:0]     r_count, n_count;
    logic [FIFO_AW-1:0]   wr_next;

    assign wr_next = r_wr + FIFO_AW'(1);

    // Pointer and fill bookkeeping.
    always_comb begin
        n_wr    = r_wr + FIFO_AW'(i_push.count);
        n_rd    = i_pop ? r_rd + FIFO_AW'(1) : r_rd;
        n_count = r_count + (FIFO_AW + 1)'(i_push.count) - (FIFO_AW + 1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Result storage; entries carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_next] <= i_push.res1;
        end
    end

    // Head of the queue and status.
    assign o_valid               = (r_count != '0);
    assign o_head                = r_mem[r_rd];
    assign o_status.count        = r_count;
    assign o_status.room_for_two = (r_count <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));

endmodule

// File: design/flac_metadata_block_locator.sv
// Top level of the FLAC metadata block locator.
`timescale 1ns / 1ps

// The locator takes one file byte per cycle while input ready is high and finds
// the first FLAC metadata block of the type held in wanted_type, skipping a leading
// ID3v2 tag. Each byte is parsed in the cycle of its transfer and its results (none,
// one, or two when the stream also ends early) are written into a four-entry result
// queue, so a result can be taken in the cycle after the byte that caused it. Input
// ready is high while the queue has room for two results; with the result side taking
// every cycle the block sustains one byte per cycle. wanted_type is sampled at the
// first byte of each block header; the user must write it only while the block is idle, which the block does not check.
module flac_metadata_block_locator
    import flm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [6:0] i_cfg_wr_data,
    flm_in_if.sink     i_in,
    flm_out_if.source  o_out
);

    logic [6:0]   r_wanted_type;
    logic         in_xfer;
    logic         out_xfer;
    t_push        push;
    t_result      head;
    logic         head_valid;
    t_fifo_status fifo_status;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wanted_type <= 7'd6;
        end else if (i_cfg_wr_en) begin
            r_wanted_type <= i_cfg_wr_data;
        end
    end

    // Handshakes.
    assign i_in.ready = fifo_status.room_for_two;
    assign in_xfer    = i_in.valid && i_in.ready;
    assign out_xfer   = head_valid && o_out.ready;

    flm_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_xfer),
        .i_data_byte   (i_in.data_byte),
        .i_first_byte  (i_in.first_byte),
        .i_final_byte  (i_in.final_byte),
        .i_wanted_type (r_wanted_type),
        .o_push        (push)
    );

    flm_result_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (out_xfer),
        .o_valid  (head_valid),
        .o_head   (head),
        .o_status (fifo_status)
    );

    // Result channel.
    assign o_out.valid          = head_valid;
    assign o_out.kind           = head.kind;
    assign o_out.payload_byte   = head.payload_byte;
    assign o_out.payload_last   = head.payload_last;
    assign o_out.block_length   = head.block_length;
    assign o_out.payload_offset = head.payload_offset;

    // Results are only written on an input transfer.
    a_push_on_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.count != 2'd0) |-> in_xfer)
        else $error("results written without an input transfer");

    // The queue never holds more than its depth.
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_status.count <= (FIFO_AW + 1)'(FIFO_DEPTH))
        else $error("result queue overflow");

    // A second result from one byte is always the early-end report.
    a_second_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.count == 2'd2) |-> (push.res1.kind == KIND_EARLY_END))
        else $error("second result of a byte is not an early-end report");

    // A byte is taken only while the queue has room for both of its results.
    a_ready_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |-> (fifo_status.count <= (FIFO_AW + 1)'(FIFO_DEPTH - 2)))
        else $error("result queue accepted a byte without room");

endmodule
